/* hdl/fat16dd_pkg.sv */
// Package for the FAT16 directory entry decoder: table sizing, marks,
// word types and state machine encodings.
// No dependencies; every other file imports it.
package fat16dd_pkg;

   // Allocation table geometry.
   localparam int TABLE_ENTRIES = 4096;
   localparam int TABLE_IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int WALK_CNT_W    = $clog2(TABLE_ENTRIES + 1);

   // Marks and masks of the directory entry format.
   localparam logic [15:0] END_MARK       = 16'hFFF8;
   localparam logic [7:0]  DELETED_MARK   = 8'hE5;
   localparam logic [7:0]  SKIP_ATTR_BITS = 8'h03;
   localparam logic [7:0]  DIR_ATTR_BIT   = 8'h10;
   localparam logic [11:0] YEAR_BASE      = 12'd1980;

   typedef enum logic {
      OP_LOAD   = 1'b0,
      OP_DECODE = 1'b1
   } op_type;

   // Request word.
   typedef struct packed {
      op_type      op;
      logic [11:0] fat_index;
      logic [15:0] fat_value;
      logic [7:0]  name_first_byte;
      logic [7:0]  attr_byte;
      logic [31:0] size_word;
      logic [15:0] time_word;
      logic [15:0] date_word;
      logic [15:0] head_cluster;
   } req_type;

   // Response word.
   typedef struct packed {
      logic        skipped;
      logic [5:0]  attr_flags;
      logic [31:0] byte_size;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [4:0]  day;
      logic [3:0]  month;
      logic [11:0] year;
      logic [12:0] cluster_count;
      logic        regular_file;
      logic        chain_broken;
   } rsp_type;

   // Control from the top level to the chain walker.
   typedef struct packed {
      logic        start;
      logic [15:0] head_cluster;
   } walk_ctl_type;

   // Status from the chain walker back to the top level.
   typedef struct packed {
      logic                  done;
      logic                  broken;
      logic [WALK_CNT_W-1:0] count;
   } walk_stat_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_RESULT
   } top_state_type;

   typedef enum logic [1:0] {
      WK_IDLE,
      WK_FIRST,
      WK_LINK
   } walk_state_type;

endpackage

/* hdl/fat16_dir_entry_decoder.sv */
// Top level of the FAT16 directory entry decoder.
// Depends on fat16dd_pkg, fat16dd_table_ram and fat16dd_walker.
//
// Usage:
//   The req_ channel carries one word per item. A load word (op = OP_LOAD)
//   writes fat_value into allocation table entry fat_index and gives no
//   response. A decode word (op = OP_DECODE) gives one response word on the
//   rsp_ channel.
//   A deleted entry, or one with the read-only or hidden bit set, gives a
//   response with only skipped set.
//   Otherwise the cluster chain is walked through the table memory, one
//   link per cycle, since each address is the word just read.
//   req_ready is high only while no decode is in progress; a finished
//   response waits in the output register, and the block takes further
//   words meanwhile. A decode that finishes while the receiver still stalls
//   waits until the output register is free.
//   Reset clears the control state and the walk count; table contents are
//   undefined until loaded, and every entry a chain reaches must be loaded.
module fat16_dir_entry_decoder
   import fat16dd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   top_state_type         state_ff, state_in;
   req_type               item_ff, item_in;
   logic                  skip_ff, skip_in;
   logic                  broken_ff, broken_in;
   logic [WALK_CNT_W-1:0] count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                   req_take;
   logic                   is_skip;
   logic                   out_free;
   logic                   wr_en;
   logic [TABLE_IDX_W-1:0] wr_addr;
   logic                   rd_en;
   logic [TABLE_IDX_W-1:0] rd_addr;
   logic [15:0]            rd_data;
   walk_ctl_type           walk_ctl;
   walk_stat_type          walk_stat;
   rsp_type                result;

   fat16dd_table_ram u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_data.fat_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   fat16dd_walker u_walker (
      .clock   (clock),
      .reset   (reset),
      .ctl     (walk_ctl),
      .stat    (walk_stat),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      skip_ff     <= skip_in;
      broken_ff   <= broken_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Handshake and table write decode.
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      req_take  = req_valid && req_ready;
      is_skip   = (req_data.name_first_byte == DELETED_MARK) ||
                  ((req_data.attr_byte & SKIP_ATTR_BITS) != 8'h00);
      out_free  = !rsp_valid_ff || rsp_ready;
      wr_en     = req_take && (req_data.op == OP_LOAD) &&
                  ({20'd0, req_data.fat_index} < 32'(TABLE_ENTRIES));
      wr_addr   = TABLE_IDX_W'(req_data.fat_index);
   end

   // Field unpacking of the held entry.
   always_comb begin
      result = '0;
      if (skip_ff) begin
         result.skipped = 1'b1;
      end else begin
         result.attr_flags    = item_ff.attr_byte[5:0];
         result.byte_size     = item_ff.size_word;
         result.hour          = item_ff.time_word[15:11];
         result.minute        = item_ff.time_word[10:5];
         result.second        = {item_ff.time_word[4:0], 1'b0};
         result.day           = item_ff.date_word[4:0];
         result.month         = item_ff.date_word[8:5];
         result.year          = 12'(item_ff.date_word[15:9]) + YEAR_BASE;
         result.cluster_count = 13'(count_ff);
         result.regular_file  = ((item_ff.attr_byte & DIR_ATTR_BIT) == 8'h00);
         result.chain_broken  = broken_ff;
      end
   end

   // Sequencing of a decode and the output register.
   always_comb begin
      state_in              = state_ff;
      item_in               = item_ff;
      skip_in               = skip_ff;
      broken_in             = broken_ff;
      count_in              = count_ff;
      rsp_data_in           = rsp_data_ff;
      rsp_valid_in          = rsp_valid_ff && !rsp_ready;
      walk_ctl.start        = 1'b0;
      walk_ctl.head_cluster = req_data.head_cluster;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_data.op == OP_DECODE)) begin
               item_in = req_data;
               skip_in = is_skip;
               if (is_skip) begin
                  state_in = ST_RESULT;
               end else begin
                  walk_ctl.start = 1'b1;
                  state_in       = ST_WALK;
               end
            end
         end
         ST_WALK: begin
            if (walk_stat.done) begin
               broken_in = walk_stat.broken;
               count_in  = walk_stat.count;
               state_in  = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_data_in  = result;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hdl/fat16dd_table_ram.sv */
// Allocation table storage: one write port, one read port, registered read.
// Depends on fat16dd_pkg for the table geometry.
module fat16dd_table_ram
   import fat16dd_pkg::*;
(
   input  logic                   clock,
   input  logic                   wr_en,
   input  logic [TABLE_IDX_W-1:0] wr_addr,
   input  logic [15:0]            wr_data,
   input  logic                   rd_en,
   input  logic [TABLE_IDX_W-1:0] rd_addr,
   output logic [15:0]            rd_data
);

   logic [15:0] mem [TABLE_ENTRIES];
   logic [15:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/fat16dd_walker.sv */
// Cluster chain walker: follows the allocation table one link per cycle.
// Depends on fat16dd_pkg; drives the read port of fat16dd_table_ram.
module fat16dd_walker
   import fat16dd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  walk_ctl_type           ctl,
   output walk_stat_type          stat,
   output logic                   rd_en,
   output logic [TABLE_IDX_W-1:0] rd_addr,
   input  logic [15:0]            rd_data
);

   walk_state_type        state_ff, state_in;
   logic [15:0]           cur_ff, cur_in;
   logic [WALK_CNT_W-1:0] cnt_ff, cnt_in;

   logic [15:0] cur_v;
   logic        at_end;
   logic        off_table;
   logic        too_long;

   // State and walk count registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= WK_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   // The cluster under test is the start cluster on the first step and the
   // word just read from the table on every later one.
   always_comb begin
      cur_v     = (state_ff == WK_LINK) ? rd_data : cur_ff;
      at_end    = (cur_v >= END_MARK);
      off_table = ({1'b0, cur_v} >= 17'(TABLE_ENTRIES));
      too_long  = (cnt_ff >= WALK_CNT_W'(TABLE_ENTRIES));
   end

   // Next state and outputs.
   always_comb begin
      state_in    = state_ff;
      cur_in      = cur_ff;
      cnt_in      = cnt_ff;
      rd_en       = 1'b0;
      rd_addr     = cur_v[TABLE_IDX_W-1:0];
      stat.done   = 1'b0;
      stat.broken = 1'b0;
      stat.count  = cnt_ff;
      unique case (state_ff)
         WK_IDLE: begin
            if (ctl.start) begin
               cur_in   = ctl.head_cluster;
               cnt_in   = '0;
               state_in = WK_FIRST;
            end
         end
         WK_FIRST, WK_LINK: begin
            priority if (at_end) begin
               stat.done = 1'b1;
               state_in  = WK_IDLE;
            end else if (off_table || too_long) begin
               stat.done   = 1'b1;
               stat.broken = 1'b1;
               state_in    = WK_IDLE;
            end else begin
               // Fetch the next link and count it.
               rd_en    = 1'b1;
               cnt_in   = cnt_ff + 1'b1;
               state_in = WK_LINK;
            end
         end
         default: begin
            state_in = WK_IDLE;
         end
      endcase
   end

endmodule
